[rtl/gcm_pkg.sv]
package gcm_pkg;

  // Color word: red 23:16, green 15:8, blue 7:0
  localparam int COLOR_BITS   = 24;
  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CHANNELS = 3;

  typedef logic [COLOR_BITS-1:0] color_t;

  // Stop count register
  localparam int                  COUNT_BITS  = 3;
  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd2;
  localparam logic [COUNT_BITS-1:0] MIN_STOPS   = 3'd2;

  // Configuration register map
  localparam int                       CFG_INDEX_BITS = 4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_COUNT = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_FIRST = 4'd1;

endpackage

[rtl/gcm_cfg_regs.sv]
module gcm_cfg_regs #(
  parameter int MAX_STOPS  = 7,
  parameter int VALUE_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [gcm_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
  input  logic [gcm_pkg::COLOR_BITS+VALUE_BITS-1:0]     cfg_data,
  output logic signed [VALUE_BITS-1:0]                  stop_value [MAX_STOPS],
  output gcm_pkg::color_t                               stop_color [MAX_STOPS],
  output logic [gcm_pkg::COUNT_BITS-1:0]                last_stop
);
  import gcm_pkg::*;

  localparam int STOP_BITS = COLOR_BITS + VALUE_BITS;
  localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_STOPS);

  logic [COUNT_BITS-1:0] stop_count;
  logic [STOP_BITS-1:0]  stop_reg [MAX_STOPS];
  logic [COUNT_BITS-1:0] count_used;

  assign cfg_ready = 1'b1;

  // Take register writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= COUNT_RESET;
      for (int i = 0; i < MAX_STOPS; i++) begin
        stop_reg[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_STOP_COUNT) begin
        stop_count <= cfg_data[COUNT_BITS-1:0];
      end
      for (int i = 0; i < MAX_STOPS; i++) begin
        if (cfg_index == REG_STOP_FIRST + CFG_INDEX_BITS'(i)) begin
          stop_reg[i] <= cfg_data;
        end
      end
    end
  end

  // Clamp the stop count into the supported range
  always_comb begin
    if (stop_count < MIN_STOPS) begin
      count_used = MIN_STOPS;
    end else if (stop_count > MAX_COUNT) begin
      count_used = MAX_COUNT;
    end else begin
      count_used = stop_count;
    end
    last_stop = count_used - COUNT_BITS'(1);
  end

  // Split each stop into value and color
  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      stop_value[i] = stop_reg[i][STOP_BITS-1:COLOR_BITS];
      stop_color[i] = stop_reg[i][COLOR_BITS-1:0];
    end
  end

endmodule

[rtl/gcm_segment.sv]
module gcm_segment #(
  parameter int MAX_STOPS  = 7,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [VALUE_BITS-1:0]      sample_value,
  input  logic signed [VALUE_BITS-1:0]      stop_value [MAX_STOPS],
  input  gcm_pkg::color_t                   stop_color [MAX_STOPS],
  input  logic [gcm_pkg::COUNT_BITS-1:0]    last_stop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [VALUE_BITS-1:0]             num,
  output logic [VALUE_BITS-1:0]             den,
  output gcm_pkg::color_t                   from_color,
  output gcm_pkg::color_t                   to_color
);
  import gcm_pkg::*;

  // Compare stage
  logic                         cmp_valid;
  logic                         cmp_ready;
  logic                         cmp_ge [MAX_STOPS];
  logic signed [VALUE_BITS-1:0] cmp_value;

  // Select stage next values
  logic                  sel_ready;
  logic [VALUE_BITS-1:0] num_next;
  logic [VALUE_BITS-1:0] den_next;
  color_t                from_next;
  color_t                to_next;
  logic                  found;
  logic                  last_ge;
  color_t                last_color;

  assign sel_ready = !out_valid || out_ready;
  assign cmp_ready = !cmp_valid || sel_ready;
  assign in_ready  = cmp_ready;

  // Compare the sample against every stop
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else if (cmp_ready) begin
      cmp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_ready && in_valid) begin
      cmp_value <= sample_value;
      for (int i = 0; i < MAX_STOPS; i++) begin
        cmp_ge[i] <= sample_value >= stop_value[i];
      end
    end
  end

  // Pick the first matching case: below first stop, a segment, at or above last stop
  always_comb begin
    last_ge    = 1'b0;
    last_color = '0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (COUNT_BITS'(i) == last_stop) begin
        last_ge    = cmp_ge[i];
        last_color = stop_color[i];
      end
    end

    found     = 1'b0;
    num_next  = '0;
    den_next  = '0;
    from_next = '0;
    to_next   = '0;
    if (!cmp_ge[0]) begin
      found     = 1'b1;
      from_next = stop_color[0];
      to_next   = stop_color[0];
    end
    for (int i = 0; i < MAX_STOPS - 1; i++) begin
      if (!found && COUNT_BITS'(i) < last_stop && cmp_ge[i] && !cmp_ge[i+1]) begin
        found     = 1'b1;
        num_next  = cmp_value - stop_value[i];
        den_next  = stop_value[i+1] - stop_value[i];
        from_next = stop_color[i];
        to_next   = stop_color[i+1];
      end
    end
    if (!found && last_ge) begin
      from_next = last_color;
      to_next   = last_color;
    end
  end

  // Hold the selected segment for the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sel_ready) begin
      out_valid <= cmp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_ready && cmp_valid) begin
      num        <= num_next;
      den        <= den_next;
      from_color <= from_next;
      to_color   <= to_next;
    end
  end

endmodule

[rtl/gcm_divider.sv]
module gcm_divider #(
  parameter int VALUE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [VALUE_BITS-1:0]    num,
  input  logic [VALUE_BITS-1:0]    den,
  input  gcm_pkg::color_t          from_color,
  input  gcm_pkg::color_t          to_color,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FRACTION_BITS-1:0] fraction,
  output gcm_pkg::color_t          out_from,
  output gcm_pkg::color_t          out_to
);
  import gcm_pkg::*;

  localparam int LAST = FRACTION_BITS - 1;

  // One quotient bit per stage; the last stage keeps no remainder
  logic                     st_valid [FRACTION_BITS];
  logic                     st_ready [FRACTION_BITS];
  logic [VALUE_BITS-1:0]    st_rem   [LAST];
  logic [VALUE_BITS-1:0]    st_den   [LAST];
  logic [FRACTION_BITS-1:0] st_q     [FRACTION_BITS];
  color_t                   st_from  [FRACTION_BITS];
  color_t                   st_to    [FRACTION_BITS];

  assign in_ready = st_ready[0];

  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_stage
    logic                     valid_in;
    logic [VALUE_BITS-1:0]    rem_in;
    logic [VALUE_BITS-1:0]    den_in;
    logic [FRACTION_BITS-1:0] q_in;
    color_t                   from_in;
    color_t                   to_in;
    logic [VALUE_BITS:0]      shifted;
    logic                     take;
    logic [VALUE_BITS-1:0]    rem_next;

    if (k == 0) begin : g_head
      assign valid_in = in_valid;
      assign rem_in   = num;
      assign den_in   = den;
      assign q_in     = '0;
      assign from_in  = from_color;
      assign to_in    = to_color;
    end else begin : g_body
      assign valid_in = st_valid[k-1];
      assign rem_in   = st_rem[k-1];
      assign den_in   = st_den[k-1];
      assign q_in     = st_q[k-1];
      assign from_in  = st_from[k-1];
      assign to_in    = st_to[k-1];
    end

    if (k == LAST) begin : g_tail_ready
      assign st_ready[k] = !st_valid[k] || out_ready;
    end else begin : g_mid_ready
      assign st_ready[k] = !st_valid[k] || st_ready[k+1];
    end

    // Restoring step: shift, trial subtract, keep on no borrow
    assign shifted  = {rem_in, 1'b0};
    assign take     = shifted >= {1'b0, den_in};
    assign rem_next = take ? VALUE_BITS'(shifted - {1'b0, den_in}) : shifted[VALUE_BITS-1:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (st_ready[k]) begin
        st_valid[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (st_ready[k] && valid_in) begin
        st_q[k]    <= {q_in[FRACTION_BITS-2:0], take};
        st_from[k] <= from_in;
        st_to[k]   <= to_in;
      end
    end

    if (k < LAST) begin : g_carry
      always_ff @(posedge clk) begin
        if (st_ready[k] && valid_in) begin
          st_rem[k] <= rem_next;
          st_den[k] <= den_in;
        end
      end
    end
  end

  assign out_valid = st_valid[LAST];
  assign fraction  = st_q[LAST];
  assign out_from  = st_from[LAST];
  assign out_to    = st_to[LAST];

endmodule

[rtl/gcm_blend.sv]
module gcm_blend #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FRACTION_BITS-1:0] fraction,
  input  gcm_pkg::color_t          from_color,
  input  gcm_pkg::color_t          to_color,
  output logic                     out_valid,
  input  logic                     out_ready,
  output gcm_pkg::color_t          rgb_color
);
  import gcm_pkg::*;

  localparam int PROD_BITS = CHANNEL_BITS + FRACTION_BITS + 2;

  // Multiply stage
  logic                        mul_valid;
  logic                        mul_ready;
  logic signed [PROD_BITS-1:0] mul_prod [NUM_CHANNELS];
  logic [CHANNEL_BITS-1:0]     mul_base [NUM_CHANNELS];
  color_t                      rgb_next;

  assign in_ready  = mul_ready;
  assign mul_ready = !mul_valid || (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= in_valid;
    end
  end

  // Form (to - from) * fraction per channel
  always_ff @(posedge clk) begin
    if (mul_ready && in_valid) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        mul_base[c] <= from_color[c*CHANNEL_BITS +: CHANNEL_BITS];
        mul_prod[c] <= PROD_BITS'(
          ($signed({1'b0, to_color[c*CHANNEL_BITS +: CHANNEL_BITS]})
           - $signed({1'b0, from_color[c*CHANNEL_BITS +: CHANNEL_BITS]}))
          * $signed({1'b0, fraction}));
      end
    end
  end

  // Add the scaled base and drop the fraction bits
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      logic signed [PROD_BITS-1:0] sum;
      sum = $signed({2'b00, mul_base[c], FRACTION_BITS'(0)}) + mul_prod[c];
      rgb_next[c*CHANNEL_BITS +: CHANNEL_BITS] = sum[FRACTION_BITS +: CHANNEL_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!out_valid || out_ready) && mul_valid) begin
      rgb_color <= rgb_next;
    end
  end

endmodule

[rtl/gradient_color_map_top.sv]
// Piecewise-linear color map. Each signed fixed-point sample is colored through a
// gradient of up to MAX_STOPS configured stops: below the first stop it takes the
// first color, at or above the last stop in use the last color, and inside a
// segment each channel is blended by a truncated FRACTION_BITS-bit fraction. The
// block takes one sample per clock while in_stall is low; two stages compare the
// sample with the stops and pick the segment, the fraction comes from a restoring
// divider with one quotient bit per stage, and two stages multiply and add the
// channel blend. The output register holds a stalled result while upstream stages
// keep filling; in_stall rises only once every stage holds an item. Stop registers
// reset to zero and the stop count to two; change them only while no samples are
// in flight.
module gradient_color_map_top #(
  parameter int MAX_STOPS     = 7,
  parameter int VALUE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [gcm_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [gcm_pkg::COLOR_BITS+VALUE_BITS-1:0] cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [VALUE_BITS-1:0]              sample_value,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output gcm_pkg::color_t                           rgb_color
);
  import gcm_pkg::*;

  logic signed [VALUE_BITS-1:0] stop_value [MAX_STOPS];
  color_t                       stop_color [MAX_STOPS];
  logic [COUNT_BITS-1:0]        last_stop;

  logic                     seg_in_ready;
  logic                     seg_valid;
  logic                     seg_ready;
  logic [VALUE_BITS-1:0]    seg_num;
  logic [VALUE_BITS-1:0]    seg_den;
  color_t                   seg_from;
  color_t                   seg_to;

  logic                     div_valid;
  logic                     div_ready;
  logic [FRACTION_BITS-1:0] div_fraction;
  color_t                   div_from;
  color_t                   div_to;

  assign in_stall = !seg_in_ready;

  gcm_cfg_regs #(
    .MAX_STOPS (MAX_STOPS),
    .VALUE_BITS(VALUE_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stop_value(stop_value),
    .stop_color(stop_color),
    .last_stop (last_stop)
  );

  gcm_segment #(
    .MAX_STOPS (MAX_STOPS),
    .VALUE_BITS(VALUE_BITS)
  ) u_segment (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (seg_in_ready),
    .sample_value(sample_value),
    .stop_value  (stop_value),
    .stop_color  (stop_color),
    .last_stop   (last_stop),
    .out_valid   (seg_valid),
    .out_ready   (seg_ready),
    .num         (seg_num),
    .den         (seg_den),
    .from_color  (seg_from),
    .to_color    (seg_to)
  );

  gcm_divider #(
    .VALUE_BITS   (VALUE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg_valid),
    .in_ready  (seg_ready),
    .num       (seg_num),
    .den       (seg_den),
    .from_color(seg_from),
    .to_color  (seg_to),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .fraction  (div_fraction),
    .out_from  (div_from),
    .out_to    (div_to)
  );

  gcm_blend #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .fraction  (div_fraction),
    .from_color(div_from),
    .to_color  (div_to),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .rgb_color (rgb_color)
  );

endmodule

[rtl/gcm_checker.sv]
module gcm_checker #(
  parameter int VALUE_BITS = 32
) (
  input logic                                      clk,
  input logic                                      rst,
  input logic                                      cfg_valid,
  input logic                                      cfg_ready,
  input logic                                      in_valid,
  input logic                                      in_stall,
  input logic signed [VALUE_BITS-1:0]              sample_value,
  input logic                                      out_valid,
  input logic                                      out_stall,
  input gcm_pkg::color_t                           rgb_color
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // A stalled result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rgb_color))
    else $error("stalled result changed or dropped");

  // A stalled sample holds until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(sample_value))
    else $error("stalled sample changed or dropped");

  // Input backs up only when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // Register writes are never refused
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind gradient_color_map_top gcm_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_gcm_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .sample_value(sample_value),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .rgb_color   (rgb_color)
);
